[sv/md5_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

  // Chaining words after reset and after each digest.
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // Padding and block layout.
  localparam logic [7:0] PadMark    = 8'h80;
  localparam logic [5:0] LenBytePos = 6'd56;
  localparam logic [5:0] LastBytePos = 6'd63;
  localparam logic [1:0] QueueDepth = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  // One finished block held in the buffer memory.
  typedef struct packed {
    logic slot;
    logic final_blk;
  } blk_desc_t;

  // Word write into the block buffer.
  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } buf_wr_t;

  typedef enum logic [1:0] {
    FR_INTAKE,
    FR_MARK,
    FR_ZERO,
    FR_LEN
  } front_state_e;

  typedef enum logic [2:0] {
    EN_IDLE,
    EN_PREP0,
    EN_PREP1,
    EN_ROUND,
    EN_FINISH
  } eng_state_e;

  // Sine-derived additive constant of each round.
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left rotation amount of each round.
  function automatic logic [4:0] round_rot(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by each round.
  function automatic logic [3:0] round_word(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(r[3:0] * 4'd3 + 4'd5);
      2'd3:    g = 4'(r[3:0] * 4'd7);
      default: g = r[3:0];
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[sv/md5_intake.sv]
`timescale 1ns / 1ps
`default_nettype none

module md5_intake
  import md5_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  in_item_i,
  input  wire logic [1:0] q_count_i,
  output logic           q_push_o,
  output blk_desc_t      q_desc_o,
  output buf_wr_t        buf_wr_o
);

  front_state_e state_q, state_d;
  logic [5:0]  pos_q;
  logic [23:0] acc_q;
  logic        slot_q;
  logic [63:0] bit_count_q;
  logic [63:0] len_q;

  logic       slot_free;
  logic       accept;
  logic       byte_en;
  logic [7:0] byte_val;
  logic [5:0] pos_inc;
  logic [63:0] bit_count_inc;

  assign slot_free     = (q_count_i < QueueDepth);
  assign full          = !((state_q == FR_INTAKE) && slot_free);
  assign accept        = push && !full;
  assign pos_inc       = pos_q + 6'd1;
  assign bit_count_inc = bit_count_q + {60'd0, in_item_i.has_data, 3'b000};

  // Next state: intake, then the marker byte, zero fill and length bytes.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_INTAKE: begin
        if (accept && in_item_i.is_last) state_d = FR_MARK;
      end
      FR_MARK: begin
        if (slot_free) state_d = (pos_inc == LenBytePos) ? FR_LEN : FR_ZERO;
      end
      FR_ZERO: begin
        if (slot_free && (pos_inc == LenBytePos)) state_d = FR_LEN;
      end
      FR_LEN: begin
        if (slot_free && (pos_q == LastBytePos)) state_d = FR_INTAKE;
      end
      default: state_d = FR_INTAKE;
    endcase
  end

  // Byte selection for the current state.
  always_comb begin
    byte_en  = 1'b0;
    byte_val = 8'h00;
    case (state_q)
      FR_INTAKE: begin
        byte_en  = accept && in_item_i.has_data;
        byte_val = in_item_i.data_byte;
      end
      FR_MARK: begin
        byte_en  = slot_free;
        byte_val = PadMark;
      end
      FR_ZERO: begin
        byte_en  = slot_free;
        byte_val = 8'h00;
      end
      FR_LEN: begin
        byte_en  = slot_free;
        byte_val = len_q[{pos_q[2:0], 3'b000} +: 8];
      end
      default: begin
        byte_en  = 1'b0;
        byte_val = 8'h00;
      end
    endcase
  end

  // Every fourth byte completes a little-endian word of the buffer.
  assign buf_wr_o.en   = byte_en && (pos_q[1:0] == 2'd3);
  assign buf_wr_o.addr = {slot_q, pos_q[5:2]};
  assign buf_wr_o.data = {byte_val, acc_q};

  // The last byte of a block hands the block to the engine.
  assign q_push_o           = byte_en && (pos_q == LastBytePos);
  assign q_desc_o.slot      = slot_q;
  assign q_desc_o.final_blk = (state_q == FR_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FR_INTAKE;
      pos_q       <= 6'd0;
      slot_q      <= 1'b0;
      bit_count_q <= 64'd0;
    end else begin
      state_q <= state_d;
      if (byte_en) pos_q <= pos_inc;
      if (q_push_o) slot_q <= !slot_q;
      if (accept) begin
        bit_count_q <= in_item_i.is_last ? 64'd0 : bit_count_inc;
      end
    end
  end

  // Payload registers: partial word and latched message length.
  always_ff @(posedge clk_i) begin
    if (byte_en) acc_q <= {byte_val, acc_q[23:8]};
    if (accept && in_item_i.is_last) len_q <= bit_count_inc;
  end

endmodule

`default_nettype wire

[sv/md5_blk_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module md5_blk_queue
  import md5_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire blk_desc_t desc_i,
  input  wire logic      pop_i,
  output blk_desc_t      head_o,
  output logic [1:0]     count_o
);

  blk_desc_t  entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign head_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  // Two-entry ring of finished blocks; the writer never pushes when full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= desc_i;
  end

endmodule

`default_nettype wire

[sv/md5_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module md5_engine
  import md5_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire buf_wr_t   buf_wr_i,
  input  wire blk_desc_t head_i,
  input  wire logic [1:0] q_count_i,
  output logic           q_pop_o,
  input  wire logic      pop,
  output logic           out_valid_o,
  output out_item_t      out_item_o
);

  // Block buffer: two slots of sixteen words.
  logic [31:0] mem_q [32];
  logic [31:0] rd_q;
  logic [4:0]  rd_addr;

  eng_state_e  state_q, state_d;
  logic [5:0]  round_q;
  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] pre_q;
  logic [31:0] digest_q [4];
  logic        out_valid_q;
  logic [1:0]  out_idx_q;

  logic [31:0] f_val;
  logic [31:0] mix;
  logic [63:0] mix_dup;
  logic [31:0] b_new;
  logic [5:0]  rd_round;
  logic        can_finish;

  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) mem_q[buf_wr_i.addr] <= buf_wr_i.data;
    rd_q <= mem_q[rd_addr];
  end

  assign can_finish = !head_i.final_blk || !out_valid_q;

  // Next state of the round sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      EN_IDLE:   if (q_count_i != 2'd0) state_d = EN_PREP0;
      EN_PREP0:  state_d = EN_PREP1;
      EN_PREP1:  state_d = EN_ROUND;
      EN_ROUND:  if (round_q == 6'd63) state_d = EN_FINISH;
      EN_FINISH: if (can_finish) state_d = EN_IDLE;
      default:   state_d = EN_IDLE;
    endcase
  end

  // Word reads run two rounds ahead of the round being computed.
  always_comb begin
    case (state_q)
      EN_PREP0: rd_round = 6'd0;
      EN_PREP1: rd_round = 6'd1;
      default:  rd_round = round_q + 6'd2;
    endcase
    rd_addr = {head_i.slot, round_word(rd_round)};
    q_pop_o = (state_q == EN_FINISH) && can_finish;
  end

  // One compression round.
  always_comb begin
    case (round_q[5:4])
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_val = (d_q & b_q) | (~d_q & c_q);
      2'd2:    f_val = b_q ^ c_q ^ d_q;
      2'd3:    f_val = c_q ^ (b_q | ~d_q);
      default: f_val = 32'h0;
    endcase
    mix     = f_val + pre_q;
    mix_dup = {mix, mix} << round_rot(round_q);
    b_new   = b_q + mix_dup[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EN_IDLE;
      round_q     <= 6'd0;
      chain_q[0]  <= InitA;
      chain_q[1]  <= InitB;
      chain_q[2]  <= InitC;
      chain_q[3]  <= InitD;
      out_valid_q <= 1'b0;
      out_idx_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      if (state_q == EN_ROUND) round_q <= round_q + 6'd1;
      // Fold the block into the chain, or restart it after the last block.
      if (q_pop_o) begin
        if (head_i.final_blk) begin
          chain_q[0] <= InitA;
          chain_q[1] <= InitB;
          chain_q[2] <= InitC;
          chain_q[3] <= InitD;
        end else begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
        end
      end
      // Publish a finished digest, or step through the one being read out.
      if (q_pop_o && head_i.final_blk) begin
        out_valid_q <= 1'b1;
        out_idx_q   <= 2'd0;
      end else if (pop && out_valid_q) begin
        out_idx_q <= out_idx_q + 2'd1;
        if (out_idx_q == 2'd3) out_valid_q <= 1'b0;
      end
    end
  end

  // Working variables and the precomputed a + K + word sum.
  always_ff @(posedge clk_i) begin
    case (state_q)
      EN_PREP0: begin
        a_q <= chain_q[0];
        b_q <= chain_q[1];
        c_q <= chain_q[2];
        d_q <= chain_q[3];
      end
      EN_PREP1: begin
        pre_q <= a_q + round_k(6'd0) + rd_q;
      end
      EN_ROUND: begin
        pre_q <= d_q + round_k(round_q + 6'd1) + rd_q;
        a_q   <= d_q;
        d_q   <= c_q;
        c_q   <= b_q;
        b_q   <= b_new;
      end
      default: begin
      end
    endcase
    if (q_pop_o && head_i.final_blk) begin
      digest_q[0] <= chain_q[0] + a_q;
      digest_q[1] <= chain_q[1] + b_q;
      digest_q[2] <= chain_q[2] + c_q;
      digest_q[3] <= chain_q[3] + d_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_item_o.digest_word = digest_q[out_idx_q];
  assign out_item_o.word_index  = out_idx_q;
  assign out_item_o.last_word   = (out_idx_q == 2'd3);

endmodule

`default_nettype wire

[sv/md5_message_digest.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one byte per cycle at intake while full is low; the round engine
// computes one round per cycle and limits the rate for whole blocks.
// After a last item, padding runs one byte per cycle while a queue slot is free;
// then up to two blocks are compressed before the first digest word is shown.
// Reset: chaining words take the initial values and the bit count clears;
// the block buffer is not cleared, since every word is written before use.

module md5_message_digest
  import md5_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item_i,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item_o
);

  logic       q_push;
  logic       q_pop;
  blk_desc_t  q_desc;
  blk_desc_t  q_head;
  logic [1:0] q_count;
  buf_wr_t    buf_wr;
  logic       out_valid;

  // Front: gathers bytes into words and appends the padding.
  md5_intake u_intake (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_count_i (q_count),
    .q_push_o  (q_push),
    .q_desc_o  (q_desc),
    .buf_wr_o  (buf_wr)
  );

  // Queue of finished blocks waiting for compression.
  md5_blk_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_desc),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .count_o (q_count)
  );

  // Back: compression rounds and digest output.
  md5_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .buf_wr_i    (buf_wr),
    .head_i      (q_head),
    .q_count_i   (q_count),
    .q_pop_o     (q_pop),
    .pop         (pop),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import md5_pkg::*;

  // Additive constant of each of the 64 rounds, round 0 first.
  localparam logic [0:63][31:0] SineK = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left rotation per round group (row) and round position within four (column).
  localparam logic [0:15][4:0] RotAmt = {
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 300;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  // Digest predictor state.
  logic [31:0] chain_h [4];
  logic [63:0] msg_bits;
  logic [7:0]  blk_bytes [64];
  logic [5:0]  fill_pos;

  out_item_t pending_digest_words [$];
  int        mismatch_cnt = 0;
  int        words_sent = 0;
  int        cycle_cnt = 0;
  int        rx_hold_left = 0;
  bit        tx_idle_en = 1'b0;
  bit        rx_idle_en = 1'b0;

  md5_message_digest dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run the 64 rounds over the gathered block and fold into the chaining words.
  function automatic void md5_compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f;
    int          g;
    int          s;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      f = f + a + SineK[i] + w[g];
      s = RotAmt[(i / 16) * 4 + (i % 4)];
      a = d;
      d = c;
      c = b;
      b = b + ((f << s) | (f >> (32 - s)));
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    blk_bytes[fill_pos] = v;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) md5_compress_block();
  endfunction

  function automatic void restart_digest();
    chain_h[0] = InitA;
    chain_h[1] = InitB;
    chain_h[2] = InitC;
    chain_h[3] = InitD;
    msg_bits = '0;
    fill_pos = '0;
  endfunction

  // Update the predictor with one accepted word; a last word queues the digest.
  function automatic void predict_word(input in_item_t it);
    logic [63:0] len;
    out_item_t   e;
    if (it.has_data) begin
      absorb_byte(it.data_byte);
      msg_bits = msg_bits + 64'd8;
    end
    if (it.is_last) begin
      len = msg_bits;
      absorb_byte(PadMark);
      while (fill_pos != LenBytePos) absorb_byte(8'h00);
      for (int k = 0; k < 8; k++) absorb_byte(len[8*k +: 8]);
      for (int k = 0; k < 4; k++) begin
        e.digest_word = chain_h[k];
        e.word_index = 2'(k);
        e.last_word = (k == 3);
        pending_digest_words.push_back(e);
      end
      restart_digest();
    end
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  task automatic offer_word(input in_item_t it);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 13) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    predict_word(it);
    words_sent++;
  endtask

  // Stop offering and wait until every predicted digest word has come back.
  task automatic wait_all_digests();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk_i);
  endtask

  // One message of len random bytes, ended on the last byte or by a bare end word.
  task automatic send_message(input int len, input bit bare_end);
    in_item_t it;
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        it.data_byte = 8'($urandom);
        it.has_data = 1'b0;
        it.is_last = 1'b0;
        offer_word(it);
      end
      it.data_byte = 8'($urandom);
      it.has_data = 1'b1;
      it.is_last = !bare_end && (n == len - 1);
      offer_word(it);
    end
    if (bare_end || len == 0) begin
      it.data_byte = 8'($urandom);
      it.has_data = 1'b0;
      it.is_last = 1'b1;
      offer_word(it);
    end
  endtask

  task automatic send_fields(input logic [7:0] v, input logic has_data, input logic is_last);
    in_item_t it;
    it.data_byte = v;
    it.has_data = has_data;
    it.is_last = is_last;
    offer_word(it);
  endtask

  // Short messages with known bytes: empty, extreme bytes, ignored words.
  task automatic test_directed();
    send_fields(8'hff, 1'b0, 1'b0);
    send_fields(8'h00, 1'b0, 1'b1);
    send_fields(8'h00, 1'b0, 1'b1);
    send_fields(8'h00, 1'b1, 1'b1);
    send_fields(8'hff, 1'b1, 1'b1);
    send_fields(8'h61, 1'b1, 1'b0);
    send_fields(8'h62, 1'b1, 1'b0);
    send_fields(8'h63, 1'b1, 1'b1);
    send_fields(8'h61, 1'b1, 1'b0);
    send_fields(8'h00, 1'b0, 1'b0);
    send_fields(8'h62, 1'b1, 1'b0);
    send_fields(8'hff, 1'b0, 1'b1);
    wait_all_digests();
  endtask

  // Lengths where the padding just fits, just spills, or fills a whole block.
  task automatic test_padding_edges();
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(64, 1'b0);
    wait_all_digests();
  endtask

  // Hold the receiver off while messages keep coming, so the input stalls.
  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_hold_left = 1500;
    for (int m = 0; m < 6; m++) begin
      send_message(int'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
    end
    wait_all_digests();
    tx_idle_en = 1'b1;
  endtask

  // Random messages, mostly short, some at the block and padding boundaries.
  task automatic test_random_messages();
    int len;
    while (words_sent < 460) begin
      if ($urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 8))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          7: len = 120;
          default: len = 128;
        endcase
      end else begin
        len = int'($urandom_range(0, 20));
      end
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      send_message(len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) wait_all_digests();
    end
  endtask

  // Receiver: random stall before each word, plus any requested hold-off.
  initial begin
    int wait_n;
    pop = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      wait_n = rx_idle_en ? $urandom_range(0, 13) : 0;
      if (wait_n != 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      while (rx_hold_left > 0) begin
        pop <= 1'b0;
        @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      @(negedge clk_i);
    end
  end

  // Counts down a receiver hold-off one cycle at a time.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) rx_hold_left--;
    end
  end

  // Compare every accepted digest word with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_digest_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected digest word %h index %0d last %0d",
                   out_item.digest_word, out_item.word_index, out_item.last_word);
        end
      end else begin
        e = pending_digest_words.pop_front();
        if (out_item.digest_word !== e.digest_word || out_item.word_index !== e.word_index ||
            out_item.last_word !== e.last_word) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("digest mismatch: expected %h idx %0d last %0d, got %h idx %0d last %0d",
                     e.digest_word, e.word_index, e.last_word,
                     out_item.digest_word, out_item.word_index, out_item.last_word);
          end
        end
      end
    end
  end

  // Guard against a hung block.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    push = 1'b0;
    in_item = '0;
    rst_ni = 1'b0;
    restart_digest();
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_padding_edges();
    test_output_backpressure();
    test_random_messages();

    wait_all_digests();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_digest_words.size() != 0) mismatch_cnt += pending_digest_words.size();
    if (mismatch_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/md5_pkg.sv
sv/md5_intake.sv
sv/md5_blk_queue.sv
sv/md5_engine.sv
sv/md5_message_digest.sv
tb/tb.sv
